// ===== sv/lpsc_pkg.sv =====
package lpsc_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int PKT_LEN_W       = 24;

  // command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [31:0] START_CODE = 32'h0000_0001;

  // One command expands to cnt_m1+1 results, bytes taken MSB first from data.
  // last marks only the final result of the command.
  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  cnt_m1;
    logic        last;
    logic        conv;
    logic        valid;
  } cmd_t;

endpackage

// ===== sv/lpsc_front.sv =====
module lpsc_front import lpsc_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 first_of_packet,
  input  logic                 last_of_packet,
  input  logic [PKT_LEN_W-1:0] packet_bytes,
  output logic                 cmd_push,
  output cmd_t                 cmd
);

  localparam int PL_W = (LENGTH_BITS < PKT_LEN_W) ? LENGTH_BITS : PKT_LEN_W;

  localparam logic [1:0] MODE_GATHER  = 2'd0;
  localparam logic [1:0] MODE_PAYLOAD = 2'd1;
  localparam logic [1:0] MODE_DROP    = 2'd2;
  localparam logic [1:0] MODE_PASS    = 2'd3;

  logic [1:0]      mode, mode_next;
  logic [31:0]     prefix_bytes, prefix_bytes_next;
  logic [1:0]      prefix_count, prefix_count_next;
  logic [PL_W-1:0] payload_left, payload_left_next;
  logic [PL_W-1:0] packet_left, packet_left_next;
  logic            unit_emitted, unit_emitted_next;

  always_comb begin
    mode_next         = mode;
    prefix_bytes_next = prefix_bytes;
    prefix_count_next = prefix_count;
    payload_left_next = payload_left;
    packet_left_next  = packet_left;
    unit_emitted_next = unit_emitted;
    cmd_push          = 1'b0;
    cmd               = '0;

    if (take) begin
      if (first_of_packet) begin
        mode_next         = MODE_GATHER;
        prefix_bytes_next = '0;
        prefix_count_next = '0;
        payload_left_next = '0;
        unit_emitted_next = 1'b0;
        packet_left_next  = packet_bytes[PL_W-1:0];
      end
      if (packet_left_next != '0) begin
        packet_left_next = packet_left_next - PL_W'(1);
      end

      case (mode_next)
        MODE_GATHER: begin
          prefix_bytes_next = {prefix_bytes_next[23:0], data_byte};
          if (prefix_count_next != 2'd3) begin
            if (!last_of_packet) begin
              prefix_count_next = prefix_count_next + 2'd1;
            end else begin
              cmd_push = 1'b1;
              if (unit_emitted_next) begin
                // trailing bytes after a conversion: bare end marker
                cmd = '{data: '0, cnt_m1: 2'd0, last: 1'b1, conv: 1'b1, valid: 1'b0};
              end else begin
                // short packet: gathered bytes pass, left aligned
                cmd = '{data: prefix_bytes_next << {2'd3 - prefix_count_next, 3'b000},
                        cnt_m1: prefix_count_next, last: 1'b1, conv: 1'b0, valid: 1'b1};
              end
              mode_next         = MODE_GATHER;
              prefix_bytes_next = '0;
              prefix_count_next = '0;
              payload_left_next = '0;
              packet_left_next  = '0;
              unit_emitted_next = 1'b0;
            end
          end else begin
            prefix_count_next = '0;
            if (prefix_bytes_next == '0 || last_of_packet ||
                prefix_bytes_next > {{(32-PL_W){1'b0}}, packet_left_next}) begin
              if (unit_emitted_next) begin
                if (last_of_packet) begin
                  cmd_push = 1'b1;
                  cmd = '{data: '0, cnt_m1: 2'd0, last: 1'b1, conv: 1'b1, valid: 1'b0};
                end else begin
                  mode_next = MODE_DROP;
                end
              end else begin
                cmd_push  = 1'b1;
                cmd = '{data: prefix_bytes_next, cnt_m1: 2'd3, last: last_of_packet,
                        conv: 1'b0, valid: 1'b1};
                mode_next = MODE_PASS;
              end
              if (last_of_packet) begin
                mode_next         = MODE_GATHER;
                prefix_bytes_next = '0;
                payload_left_next = '0;
                packet_left_next  = '0;
                unit_emitted_next = 1'b0;
              end
            end else begin
              cmd_push = 1'b1;
              cmd = '{data: START_CODE, cnt_m1: 2'd3, last: 1'b0, conv: 1'b1, valid: 1'b1};
              unit_emitted_next = 1'b1;
              // length is bounded by packet_left here, so it fits
              payload_left_next = prefix_bytes_next[PL_W-1:0];
              mode_next         = MODE_PAYLOAD;
            end
          end
        end

        MODE_PAYLOAD: begin
          cmd_push = 1'b1;
          cmd = '{data: {data_byte, 24'h0}, cnt_m1: 2'd0, last: last_of_packet,
                  conv: 1'b1, valid: 1'b1};
          if (payload_left_next != '0) begin
            payload_left_next = payload_left_next - PL_W'(1);
          end
          if (last_of_packet) begin
            mode_next         = MODE_GATHER;
            prefix_bytes_next = '0;
            prefix_count_next = '0;
            payload_left_next = '0;
            packet_left_next  = '0;
            unit_emitted_next = 1'b0;
          end else if (payload_left_next == '0) begin
            mode_next = MODE_GATHER;
          end
        end

        MODE_DROP: begin
          if (last_of_packet) begin
            cmd_push = 1'b1;
            cmd = '{data: '0, cnt_m1: 2'd0, last: 1'b1, conv: 1'b1, valid: 1'b0};
            mode_next         = MODE_GATHER;
            prefix_bytes_next = '0;
            prefix_count_next = '0;
            payload_left_next = '0;
            packet_left_next  = '0;
            unit_emitted_next = 1'b0;
          end
        end

        default: begin
          cmd_push = 1'b1;
          cmd = '{data: {data_byte, 24'h0}, cnt_m1: 2'd0, last: last_of_packet,
                  conv: 1'b0, valid: 1'b1};
          if (last_of_packet) begin
            mode_next         = MODE_GATHER;
            prefix_bytes_next = '0;
            prefix_count_next = '0;
            payload_left_next = '0;
            packet_left_next  = '0;
            unit_emitted_next = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_GATHER;
      prefix_bytes <= '0;
      prefix_count <= '0;
      payload_left <= '0;
      packet_left  <= '0;
      unit_emitted <= 1'b0;
    end else begin
      mode         <= mode_next;
      prefix_bytes <= prefix_bytes_next;
      prefix_count <= prefix_count_next;
      payload_left <= payload_left_next;
      packet_left  <= packet_left_next;
      unit_emitted <= unit_emitted_next;
    end
  end

`ifndef ASSERT_OFF
  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_PAYLOAD |-> payload_left != '0 && unit_emitted)
    else $error("payload mode with nothing left to copy");

  a_drop_needs_unit: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_DROP |-> unit_emitted)
    else $error("drop mode before any unit was converted");
`endif

endmodule

// ===== sv/lpsc_cmd_fifo.sv =====
module lpsc_cmd_fifo import lpsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push, do_pop;

  assign full     = (count == CMD_CNT_W'(CMD_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CMD_CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CMD_CNT_W'(CMD_DEPTH))
    else $error("command queue count overran its depth");
`endif

endmodule

// ===== sv/lpsc_back.sv =====
module lpsc_back import lpsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_ready,
  input  cmd_t       head,
  output logic       cmd_pop,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last,
  output logic       converted,
  output logic       empty,
  input  logic       pop
);

  logic [1:0]  idx;
  logic        occ;
  logic        load;
  logic        final_one;
  logic [31:0] head_shift;

  assign empty      = !occ;
  assign load       = cmd_ready && (!occ || pop);
  assign final_one  = (idx == head.cnt_m1);
  assign cmd_pop    = load && final_one;
  assign head_shift = head.data << {idx, 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        occ <= 1'b1;
        idx <= final_one ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        occ <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= head_shift[31:24];
      out_valid <= head.valid;
      out_last  <= head.last && final_one;
      converted <= head.conv;
    end
  end

`ifndef ASSERT_OFF
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    occ && !out_valid |-> out_last && converted && out_byte == 8'h00)
    else $error("bare end marker without last or converted");
`endif

endmodule

// ===== sv/length_prefixed_to_start_code_nal_top.sv =====
// Channel   Handshake            Payload
// input     push / full          data_byte, first_of_packet, last_of_packet, packet_bytes
// result    empty / pop          out_byte, out_valid, out_last, converted
//
// One input byte is taken per cycle unless full; one result leaves per cycle on pop.
// An in-range nonzero prefix yields four start-code results after three silent bytes.
// First result of an item goes through the command queue, then the output register.
// Front stalls only when the four-entry command queue fills; back stalls only while pop is low.
// Synchronous reset rst clears all control state; no clearing pass is needed.
module length_prefixed_to_start_code_nal_top import lpsc_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte,
  input  logic                 first_of_packet,
  input  logic                 last_of_packet,
  input  logic [PKT_LEN_W-1:0] packet_bytes,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           out_byte,
  output logic                 out_valid,
  output logic                 out_last,
  output logic                 converted
);

  logic take;
  logic cmd_push;
  cmd_t cmd;
  logic cmd_ready;
  cmd_t head;
  logic cmd_pop;

  assign take = push && !full;

  lpsc_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .data_byte       (data_byte),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .packet_bytes    (packet_bytes),
    .cmd_push        (cmd_push),
    .cmd             (cmd)
  );

  lpsc_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd),
    .full     (full),
    .pop      (cmd_pop),
    .nonempty (cmd_ready),
    .head     (head)
  );

  lpsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_ready (cmd_ready),
    .head      (head),
    .cmd_pop   (cmd_pop),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last),
    .converted (converted),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== verif/tb_length_prefixed_to_start_code_nal_top.sv =====
module tb_length_prefixed_to_start_code_nal_top;
  import lpsc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 50;
  localparam int DIR_COUNT     = 25;
  localparam int PHASE_ITEMS   = 100;
  localparam int IDLE_PCT [4]  = '{0, 59, 0, 34};
  localparam int STALL_PCT [4] = '{0, 0, 59, 34};

  typedef enum logic [1:0] {ST_GATHER, ST_PAYLOAD, ST_DROP, ST_PASS} nal_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eop;
    logic       conv;
  } nal_out_t;

  // One input byte; when chk is set the expected results are typed in the row:
  // exp_n bytes of exp_word, oldest in the highest byte, exp_eop on the final one.
  typedef struct packed {
    logic [7:0]  data;
    logic        sop;
    logic        eop;
    logic [23:0] pbytes;
    logic        chk;
    logic [2:0]  exp_n;
    logic [31:0] exp_word;
    logic        exp_valid;
    logic        exp_eop;
    logic        exp_conv;
  } nal_row_t;

  localparam nal_row_t DIR_ROWS [0:DIR_COUNT-1] = '{
    // single byte packet, smallest length
    '{8'hFF, 1'b1, 1'b1, 24'd1,       1'b1, 3'd1, 32'h0000_00FF, 1'b1, 1'b1, 1'b0},
    // short packet, largest length field
    '{8'h00, 1'b1, 1'b0, 24'hFF_FFFF, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b1, 24'h00_0000, 1'b1, 3'd3, 32'h0000_FF80, 1'b1, 1'b1, 1'b0},
    // one unit converted, then a zero length drops the rest
    '{8'h00, 1'b1, 1'b0, 24'hFF_FFFF, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd4, 32'h0000_0001, 1'b1, 1'b0, 1'b1},
    '{8'hAB, 1'b0, 1'b0, 24'h00_0000, 1'b0, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h55, 1'b0, 1'b1, 24'h00_0000, 1'b1, 3'd1, 32'h0000_0000, 1'b0, 1'b1, 1'b1},
    // first length overruns: whole packet passes through
    '{8'h00, 1'b1, 1'b0, 24'd6,       1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h09, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd4, 32'h0000_0009, 1'b1, 1'b0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 24'h00_0000, 1'b0, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h3C, 1'b0, 1'b1, 24'h00_0000, 1'b0, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    // byte with no start of packet after a finished one
    '{8'h5A, 1'b0, 1'b1, 24'h00_0000, 1'b1, 3'd1, 32'h0000_005A, 1'b1, 1'b1, 1'b0},
    // prefix completed by the final byte
    '{8'h00, 1'b1, 1'b0, 24'd4,       1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'h00_0000, 1'b1, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b1, 24'h00_0000, 1'b1, 3'd4, 32'h0000_0000, 1'b1, 1'b1, 1'b0}
  };

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [7:0]           data_byte;
  logic                 first_of_packet;
  logic                 last_of_packet;
  logic [PKT_LEN_W-1:0] packet_bytes;
  logic                 empty;
  logic                 pop;
  logic [7:0]           out_byte;
  logic                 out_valid;
  logic                 out_last;
  logic                 converted;

  length_prefixed_to_start_code_nal_top dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .data_byte       (data_byte),
    .first_of_packet (first_of_packet),
    .last_of_packet  (last_of_packet),
    .packet_bytes    (packet_bytes),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_valid       (out_valid),
    .out_last        (out_last),
    .converted       (converted)
  );

  // converter state mirror
  nal_mode_e   nal_mode;
  logic [31:0] pfx_shift;
  logic [1:0]  pfx_cnt;
  logic [31:0] payload_rem;
  logic [23:0] pkt_rem;
  logic        unit_done;

  nal_out_t step_q[$];
  nal_out_t expected_nal_q[$];
  logic [7:0] pkt_q[$];

  int  err_count  = 0;
  int  res_count  = 0;
  int  bytes_sent = 0;
  int  cycle_cnt  = 0;
  int  idle_pct   = 0;
  int  stall_pct  = 0;
  bit  hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("%0t: %s", $time, msg);
  endtask

  function automatic void clear_packet();
    nal_mode    = ST_GATHER;
    pfx_shift   = '0;
    pfx_cnt     = '0;
    payload_rem = '0;
    pkt_rem     = '0;
    unit_done   = 1'b0;
  endfunction

  // n bytes of word, oldest in the highest byte; eop marks only the final one
  function automatic void add_bytes(input logic [31:0] word, input int n, input logic valid,
                                    input logic eop, input logic conv);
    for (int k = 0; k < n; k++)
      step_q.insert(step_q.size(), '{word[8*(n-1-k) +: 8], valid, eop && (k == n - 1), conv});
  endfunction

  task automatic predict_nal_step(input logic [7:0] b, input logic sop, input logic eop,
                                  input logic [23:0] pb);
    logic [31:0] unit_len;
    step_q.delete();
    if (sop) begin
      clear_packet();
      pkt_rem = pb;
    end
    if (pkt_rem != 0) pkt_rem--;
    case (nal_mode)
      ST_GATHER: begin
        pfx_shift = {pfx_shift[23:0], b};
        if (pfx_cnt != 2'd3) begin
          if (!eop) begin
            pfx_cnt++;
          end else begin
            if (unit_done) add_bytes('0, 1, 1'b0, 1'b1, 1'b1);
            else add_bytes(pfx_shift, int'(pfx_cnt) + 1, 1'b1, 1'b1, 1'b0);
            clear_packet();
          end
        end else begin
          unit_len = pfx_shift;
          pfx_cnt  = '0;
          // a prefix on the final byte always overruns
          if (unit_len == 0 || unit_len > pkt_rem || eop) begin
            if (unit_done && eop) begin
              add_bytes('0, 1, 1'b0, 1'b1, 1'b1);
              clear_packet();
            end else if (unit_done) begin
              nal_mode = ST_DROP;
            end else begin
              add_bytes(pfx_shift, 4, 1'b1, eop, 1'b0);
              if (eop) clear_packet();
              else nal_mode = ST_PASS;
            end
          end else begin
            add_bytes(START_CODE, 4, 1'b1, 1'b0, 1'b1);
            unit_done   = 1'b1;
            payload_rem = unit_len;
            nal_mode    = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        add_bytes({24'h0, b}, 1, 1'b1, eop, 1'b1);
        if (payload_rem != 0) payload_rem--;
        if (eop) clear_packet();
        else if (payload_rem == 0) nal_mode = ST_GATHER;
      end
      ST_DROP: begin
        if (eop) begin
          add_bytes('0, 1, 1'b0, 1'b1, 1'b1);
          clear_packet();
        end
      end
      default: begin
        add_bytes({24'h0, b}, 1, 1'b1, eop, 1'b0);
        if (eop) clear_packet();
      end
    endcase
  endtask

  task automatic send_byte(input nal_row_t row);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    push            <= 1'b1;
    data_byte       <= row.data;
    first_of_packet <= row.sop;
    last_of_packet  <= row.eop;
    packet_bytes    <= row.pbytes;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_nal_step(row.data, row.sop, row.eop, row.pbytes);
    if (row.chk) begin
      step_q.delete();
      add_bytes(row.exp_word, int'(row.exp_n), row.exp_valid, row.exp_eop, row.exp_conv);
    end
    foreach (step_q[i]) expected_nal_q.insert(expected_nal_q.size(), step_q[i]);
    bytes_sent++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rst) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    nal_out_t want;
    nal_out_t got;
    if (!rst && pop && !empty) begin
      got = '{out_byte, out_valid, out_last, converted};
      if (expected_nal_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer byte=%02h valid=%0b last=%0b conv=%0b",
                                  got.data, got.valid, got.eop, got.conv));
      end else begin
        want = expected_nal_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "result %0d: byte %02h/%02h valid %0b/%0b last %0b/%0b conv %0b/%0b (got/exp)",
            res_count, got.data, want.data, got.valid, want.valid, got.eop, want.eop,
            got.conv, want.conv));
      end
      res_count++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    nal_row_t    row;
    int          unit_cnt;
    int          body_len;
    int          keep;
    logic [31:0] len_field;
    logic        pkt_sop;
    logic        pkt_eop;
    logic [23:0] pkt_pbytes;

    rst             <= 1'b1;
    push            <= 1'b0;
    data_byte       <= '0;
    first_of_packet <= 1'b0;
    last_of_packet  <= 1'b0;
    packet_bytes    <= '0;
    clear_packet();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_COUNT; i++) send_byte(DIR_ROWS[i]);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      // sender runs flat out while the result side holds off
      if (ph == 0) hold_req = 1'b1;
      while (bytes_sent < DIR_COUNT + PHASE_ITEMS * (ph + 1)) begin
        pkt_q.delete();
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 6)) pkt_q.insert(pkt_q.size(), 8'($urandom));
        end else begin
          unit_cnt = $urandom_range(1, 3);
          repeat (unit_cnt) begin
            body_len = $urandom_range(1, 8);
            case ($urandom_range(19))
              0:       len_field = '0;
              1:       len_field = body_len + 1;
              2:       len_field = $urandom;
              default: len_field = body_len;
            endcase
            for (int k = 3; k >= 0; k--) pkt_q.insert(pkt_q.size(), len_field[8*k +: 8]);
            repeat (body_len) pkt_q.insert(pkt_q.size(), 8'($urandom));
          end
          if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) pkt_q.insert(pkt_q.size(), 8'($urandom));
          // early end somewhere inside the packet
          if ($urandom_range(9) == 0) begin
            keep = $urandom_range(1, pkt_q.size());
            while (pkt_q.size() > keep) void'(pkt_q.pop_back());
          end
        end
        pkt_sop    = ($urandom_range(19) != 0);
        pkt_eop    = ($urandom_range(19) != 0);
        pkt_pbytes = ($urandom_range(9) == 0) ? 24'($urandom) : 24'(pkt_q.size());
        for (int i = 0; i < pkt_q.size(); i++) begin
          row        = '0;
          row.data   = pkt_q[i];
          row.sop    = pkt_sop && (i == 0);
          row.eop    = pkt_eop && (i == pkt_q.size() - 1);
          row.pbytes = (i == 0) ? pkt_pbytes : 24'($urandom);
          send_byte(row);
        end
      end
    end

    push      <= 1'b0;
    stall_pct = 0;
    while (expected_nal_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
